/* hw/rtl/pidcl_pkg.sv */
// ----------------------------------------------------------------------------
// pidcl_pkg
// Shared constants, register indexes and types of the clamped PID controller.
// ----------------------------------------------------------------------------
package pidcl_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int GAIN_W         = 16;
  localparam int SUM_W          = 32;
  localparam int FRAC_BITS      = 8;
  localparam int CFG_INDEX_W    = 3;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_KP_GAIN    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KI_DT      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KD_OVER_DT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CTL_MAX    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CTL_MIN    = 3'd4;

  // item kinds
  localparam logic KIND_STEP  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp_gain;
    logic signed [GAIN_W-1:0] ki_dt;
    logic signed [GAIN_W-1:0] kd_over_dt;
  } gain_set_t;

  function automatic int max_w(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

/* hw/rtl/pidcl_in_if.sv */
// ----------------------------------------------------------------------------
// pidcl_in_if
// Input channel: one beat is a control step or a clear item.
// ----------------------------------------------------------------------------
interface pidcl_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [DATA_WIDTH-1:0] measured;
  logic signed [DATA_WIDTH-1:0] setpoint;

  modport source (output valid, output kind, output measured, output setpoint, input ready);
  modport sink   (input valid, input kind, input measured, input setpoint, output ready);
endinterface

/* hw/rtl/pidcl_out_if.sv */
// ----------------------------------------------------------------------------
// pidcl_out_if
// Output channel: one beat carries one clamped control value.
// ----------------------------------------------------------------------------
interface pidcl_out_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] control;

  modport source (output valid, output control, input ready);
  modport sink   (input valid, input control, output ready);
endinterface

/* hw/rtl/pidcl_cfg_regs.sv */
// ----------------------------------------------------------------------------
// pidcl_cfg_regs
// Gain and limit registers behind the plain write port.
// ----------------------------------------------------------------------------
module pidcl_cfg_regs #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [pidcl_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [pidcl_pkg::max_w(DATA_WIDTH, pidcl_pkg::GAIN_W)-1:0] cfg_data,
  output pidcl_pkg::gain_set_t                   gains,
  output logic signed [DATA_WIDTH-1:0]           ctl_max,
  output logic signed [DATA_WIDTH-1:0]           ctl_min
);
  import pidcl_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.kp_gain    <= '0;
      gains.ki_dt      <= '0;
      gains.kd_over_dt <= '0;
      ctl_max          <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
      ctl_min          <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KP_GAIN:    gains.kp_gain    <= cfg_data[GAIN_W-1:0];
        REG_KI_DT:      gains.ki_dt      <= cfg_data[GAIN_W-1:0];
        REG_KD_OVER_DT: gains.kd_over_dt <= cfg_data[GAIN_W-1:0];
        REG_CTL_MAX:    ctl_max          <= cfg_data[DATA_WIDTH-1:0];
        REG_CTL_MIN:    ctl_min          <= cfg_data[DATA_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/pidcl_step_calc.sv */
// ----------------------------------------------------------------------------
// pidcl_step_calc
// One control step: error, saturating integral, three gain products,
// floor shift, clamp and anti-windup correction of the integral.
// ----------------------------------------------------------------------------
module pidcl_step_calc #(
  parameter int DATA_WIDTH = 16
) (
  input  pidcl_pkg::gain_set_t                 gains,
  input  logic signed [DATA_WIDTH-1:0]         ctl_max,
  input  logic signed [DATA_WIDTH-1:0]         ctl_min,
  input  logic                                 first_pending,
  input  logic signed [DATA_WIDTH-1:0]         previous_measure,
  input  logic signed [pidcl_pkg::SUM_W-1:0]   error_sum,
  input  logic signed [DATA_WIDTH-1:0]         measured,
  input  logic signed [DATA_WIDTH-1:0]         setpoint,
  output logic signed [DATA_WIDTH-1:0]         control,
  output logic signed [pidcl_pkg::SUM_W-1:0]   error_sum_next
);
  import pidcl_pkg::*;

  localparam int EW    = DATA_WIDTH + 1;
  localparam int WS    = max_w(SUM_W, EW) + 1;
  localparam int PW_P  = GAIN_W + EW;
  localparam int PW_I  = GAIN_W + SUM_W;
  localparam int ACC_W = max_w(PW_P, PW_I) + 2;

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [WS-1:0] v);
    logic in_range;
    in_range = (v[WS-1:SUM_W-1] == '0) || (v[WS-1:SUM_W-1] == '1);
    if (in_range) begin
      return v[SUM_W-1:0];
    end
    return v[WS-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
  endfunction

  logic signed [EW-1:0]         err;
  logic signed [EW-1:0]         delta;
  logic signed [DATA_WIDTH-1:0] prev_eff;
  logic signed [SUM_W-1:0]      sum_add;
  logic signed [SUM_W-1:0]      sum_hi;
  logic signed [PW_P-1:0]       term_p;
  logic signed [PW_I-1:0]       term_i;
  logic signed [PW_P-1:0]       term_d;
  logic signed [ACC_W-1:0]      acc;
  logic signed [ACC_W-1:0]      drive;
  logic signed [ACC_W-1:0]      after_hi;
  logic                         clamp_hi;
  logic                         clamp_lo;

  // derivative is zero on the first step after reset or clear
  assign prev_eff = first_pending ? measured : previous_measure;
  assign err      = EW'(setpoint) - EW'(measured);
  assign delta    = EW'(measured) - EW'(prev_eff);
  assign sum_add  = sat_sum(WS'(error_sum) + WS'(err));

  assign term_p = gains.kp_gain * err;
  assign term_i = gains.ki_dt * sum_add;
  assign term_d = gains.kd_over_dt * delta;

  assign acc   = ACC_W'(term_p) + ACC_W'(term_i) - ACC_W'(term_d);
  // arithmetic shift rounds toward minus infinity
  assign drive = acc >>> FRAC_BITS;

  assign clamp_hi = drive > ACC_W'(ctl_max);
  assign after_hi = clamp_hi ? ACC_W'(ctl_max) : drive;
  assign clamp_lo = after_hi < ACC_W'(ctl_min);

  assign control = clamp_lo ? ctl_min : (clamp_hi ? ctl_max : drive[DATA_WIDTH-1:0]);

  // each clamp that fires takes this step's error back out
  assign sum_hi         = clamp_hi ? sat_sum(WS'(sum_add) - WS'(err)) : sum_add;
  assign error_sum_next = clamp_lo ? sat_sum(WS'(sum_hi) - WS'(err)) : sum_hi;

endmodule

/* hw/rtl/pid_with_clamp_antiwindup.sv */
// ----------------------------------------------------------------------------
// pid_with_clamp_antiwindup
// PID controller with derivative on measurement and clamp anti-windup.
// ----------------------------------------------------------------------------
// Each beat on sample is registered, then one pass of logic forms the error,
// the saturating 32-bit integral, the three Q8.8 gain products, the output
// clamp and the integral correction, and writes the control value into the
// result register; a beat passes the input register, then the result
// register. A new beat is taken every cycle unless a result stall holds a
// step beat in the input register. The integral loop (saturating add, ki_dt
// multiply, sum, clamp compare, correction back into error_sum) limits the
// clock rate, a combinational path back to error_sum. Clear beats reset the
// integral and measurement history and produce no result. Gains and limits
// are written through cfg_we/cfg_index/cfg_data while the block is idle, a
// user's rule the block does not enforce; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module pid_with_clamp_antiwindup #(
  parameter int DATA_WIDTH = pidcl_pkg::DATA_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [pidcl_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [pidcl_pkg::max_w(DATA_WIDTH, pidcl_pkg::GAIN_W)-1:0] cfg_data,
  pidcl_in_if.sink                               sample,
  pidcl_out_if.source                            result
);
  import pidcl_pkg::*;

  gain_set_t                    gains;
  logic signed [DATA_WIDTH-1:0] ctl_max;
  logic signed [DATA_WIDTH-1:0] ctl_min;

  logic                         s1_valid;
  logic                         s1_kind;
  logic signed [DATA_WIDTH-1:0] s1_measured;
  logic signed [DATA_WIDTH-1:0] s1_setpoint;
  logic                         s1_adv;

  logic signed [SUM_W-1:0]      error_sum;
  logic signed [SUM_W-1:0]      error_sum_next;
  logic signed [DATA_WIDTH-1:0] previous_measure;
  logic                         first_pending;

  logic                         out_valid;
  logic signed [DATA_WIDTH-1:0] out_control;
  logic signed [DATA_WIDTH-1:0] control_next;

  pidcl_cfg_regs #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gains     (gains),
    .ctl_max   (ctl_max),
    .ctl_min   (ctl_min)
  );

  pidcl_step_calc #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_step_calc (
    .gains            (gains),
    .ctl_max          (ctl_max),
    .ctl_min          (ctl_min),
    .first_pending    (first_pending),
    .previous_measure (previous_measure),
    .error_sum        (error_sum),
    .measured         (s1_measured),
    .setpoint         (s1_setpoint),
    .control          (control_next),
    .error_sum_next   (error_sum_next)
  );

  // clear beats never need the result slot
  assign s1_adv = s1_valid && ((s1_kind == KIND_CLEAR) || !out_valid || result.ready);

  assign sample.ready   = !s1_valid || s1_adv;
  assign result.valid   = out_valid;
  assign result.control = out_control;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.valid && sample.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_kind     <= sample.kind;
      s1_measured <= sample.measured;
      s1_setpoint <= sample.setpoint;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum        <= '0;
      previous_measure <= '0;
      first_pending    <= 1'b1;
    end else if (s1_adv) begin
      if (s1_kind == KIND_CLEAR) begin
        error_sum        <= '0;
        previous_measure <= '0;
        first_pending    <= 1'b1;
      end else begin
        error_sum        <= error_sum_next;
        previous_measure <= s1_measured;
        first_pending    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && (s1_kind == KIND_STEP)) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (s1_kind == KIND_STEP)) begin
      out_control <= control_next;
    end
  end

  a_clear_resets_state: assert property (@(posedge clk) disable iff (rst)
    s1_adv && (s1_kind == KIND_CLEAR) |=> first_pending && (error_sum == '0)
      && (previous_measure == '0))
    else $error("clear beat did not reset controller state");

  a_clear_no_result: assert property (@(posedge clk) disable iff (rst)
    s1_adv && (s1_kind == KIND_CLEAR) && !out_valid |=> !out_valid)
    else $error("clear beat produced a result");

  a_step_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_adv && (s1_kind == KIND_STEP) |=> out_valid && !first_pending)
    else $error("control step did not load the result register");

  a_stage_not_lost: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_measured) && $stable(s1_setpoint))
    else $error("stalled input stage lost its beat");

endmodule

/* bench/pidcl_checker.sv */
// ----------------------------------------------------------------------------
// pidcl_checker
// Watches the sample and result channels and the configuration port of the
// clamped PID controller. Keeps its own copy of the gains, limits, integral
// and measurement history, predicts the control value for every accepted
// step beat and compares it with the result beats in order.
// ----------------------------------------------------------------------------
module pidcl_checker
  import pidcl_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int CFG_W      = max_w(DATA_WIDTH, GAIN_W)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  pidcl_in_if                    sample,
  pidcl_out_if                   result,
  output int                     mismatches,
  output int                     outstanding
);

  localparam longint SUM_HI      = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO      = -(longint'(1) <<< (SUM_W - 1));
  localparam int     MAX_REPORTS = 10;

  logic signed [GAIN_W-1:0]     kp_q;
  logic signed [GAIN_W-1:0]     ki_q;
  logic signed [GAIN_W-1:0]     kd_q;
  logic signed [DATA_WIDTH-1:0] ctl_hi;
  logic signed [DATA_WIDTH-1:0] ctl_lo;

  logic signed [SUM_W-1:0]      integral;
  logic signed [DATA_WIDTH-1:0] last_meas;
  logic                         first_sample;

  logic signed [DATA_WIDTH-1:0] expected_control[$];
  logic signed [DATA_WIDTH-1:0] want;

  function automatic logic signed [SUM_W-1:0] clip_sum(input longint v);
    if (v > SUM_HI) return SUM_HI[SUM_W-1:0];
    if (v < SUM_LO) return SUM_LO[SUM_W-1:0];
    return v[SUM_W-1:0];
  endfunction

  // one control step: updates integral and history, returns the clamped drive
  function automatic logic signed [DATA_WIDTH-1:0] next_control(
    input logic signed [DATA_WIDTH-1:0] meas,
    input logic signed [DATA_WIDTH-1:0] target
  );
    longint err;
    longint slope;
    longint acc;
    longint drive;
    if (first_sample) begin
      last_meas    = meas;
      first_sample = 1'b0;
    end
    err      = longint'(target) - longint'(meas);
    integral = clip_sum(longint'(integral) + err);
    slope    = longint'(meas) - longint'(last_meas);
    acc      = longint'(kp_q) * err + longint'(ki_q) * longint'(integral)
             - longint'(kd_q) * slope;
    drive    = acc >>> FRAC_BITS;
    // each clamp that fires backs this step's error out of the integral
    if (drive > longint'(ctl_hi)) begin
      drive    = longint'(ctl_hi);
      integral = clip_sum(longint'(integral) - err);
    end
    if (drive < longint'(ctl_lo)) begin
      drive    = longint'(ctl_lo);
      integral = clip_sum(longint'(integral) - err);
    end
    last_meas = meas;
    return drive[DATA_WIDTH-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      kp_q         = '0;
      ki_q         = '0;
      kd_q         = '0;
      ctl_hi       = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      ctl_lo       = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      integral     = '0;
      last_meas    = '0;
      first_sample = 1'b1;
      expected_control.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KP_GAIN:    kp_q   = cfg_data[GAIN_W-1:0];
          REG_KI_DT:      ki_q   = cfg_data[GAIN_W-1:0];
          REG_KD_OVER_DT: kd_q   = cfg_data[GAIN_W-1:0];
          REG_CTL_MAX:    ctl_hi = cfg_data[DATA_WIDTH-1:0];
          REG_CTL_MIN:    ctl_lo = cfg_data[DATA_WIDTH-1:0];
          default: ;
        endcase
      end
      if (sample.valid && sample.ready) begin
        if (sample.kind == KIND_CLEAR) begin
          integral     = '0;
          last_meas    = '0;
          first_sample = 1'b1;
        end else begin
          expected_control.push_back(next_control(sample.measured, sample.setpoint));
        end
      end
      if (result.valid && result.ready) begin
        if (expected_control.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result beat with nothing expected: control %0d", result.control);
        end else begin
          want = expected_control.pop_front();
          if (result.control !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("control mismatch: expected %0d, got %0d", want, result.control);
          end
        end
      end
    end
    outstanding <= expected_control.size();
  end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the clamped PID controller: directed steps at
// the field extremes, clear beats, crossed limits and extreme gains, then
// random gains, limits and loop-shaped sample traffic under four idle/stall
// mixes.
// ----------------------------------------------------------------------------
module tb;
  import pidcl_pkg::*;

  localparam int DW            = DATA_WIDTH_DEF;
  localparam int CFG_W         = max_w(DW, GAIN_W);
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BEATS  = 195;
  localparam int FIELD_HI      = 2 ** (DW - 1) - 1;
  localparam int FIELD_LO      = -(2 ** (DW - 1));

  localparam logic [DW-1:0]     CTL_TOP     = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0]     CTL_BOTTOM  = {1'b1, {(DW-1){1'b0}}};
  localparam logic [GAIN_W-1:0] GAIN_TOP    = {1'b0, {(GAIN_W-1){1'b1}}};
  localparam logic [GAIN_W-1:0] GAIN_BOTTOM = {1'b1, {(GAIN_W-1){1'b0}}};
  localparam logic [GAIN_W-1:0] GAIN_ONE    = GAIN_W'(1 << FRAC_BITS);

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int outstanding;

  pidcl_in_if  #(.DATA_WIDTH(DW)) sample_ch ();
  pidcl_out_if #(.DATA_WIDTH(DW)) result_ch ();

  pid_with_clamp_antiwindup #(.DATA_WIDTH(DW)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  pidcl_checker #(.DATA_WIDTH(DW)) u_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample      (sample_ch),
    .result      (result_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(7))
      0:       return GAIN_W'($urandom);
      1:       return $urandom_range(1) ? GAIN_TOP : GAIN_BOTTOM;
      2:       return '0;
      default: return GAIN_W'(int'($urandom_range(2048)) - 1024);
    endcase
  endfunction

  function automatic logic signed [DW-1:0] corner_value();
    case ($urandom_range(3))
      0:       return CTL_BOTTOM;
      1:       return CTL_TOP;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // all five registers, then one write to an index that maps to nothing
  task automatic load_settings(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                               input logic [GAIN_W-1:0] kd, input logic [DW-1:0] hi,
                               input logic [DW-1:0] lo);
    cfg_we    <= 1'b1;
    cfg_index <= REG_KP_GAIN;
    cfg_data  <= CFG_W'(kp);
    @(posedge clk);
    cfg_index <= REG_KI_DT;
    cfg_data  <= CFG_W'(ki);
    @(posedge clk);
    cfg_index <= REG_KD_OVER_DT;
    cfg_data  <= CFG_W'(kd);
    @(posedge clk);
    cfg_index <= REG_CTL_MAX;
    cfg_data  <= CFG_W'(hi);
    @(posedge clk);
    cfg_index <= REG_CTL_MIN;
    cfg_data  <= CFG_W'(lo);
    @(posedge clk);
    cfg_index <= CFG_INDEX_W'($urandom_range(2 ** CFG_INDEX_W - 1, REG_CTL_MIN + 1));
    cfg_data  <= CFG_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input logic k, input logic signed [DW-1:0] meas,
                           input logic signed [DW-1:0] sp);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid    <= 1'b1;
    sample_ch.kind     <= k;
    sample_ch.measured <= meas;
    sample_ch.setpoint <= sp;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // outstanding is a registered copy of the queue size, so look only after the next edge
  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    logic signed [DW-1:0] target;
    logic signed [DW-1:0] hi;
    logic signed [DW-1:0] lo;
    int roll;
    int v;

    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_KP_GAIN;
    cfg_data           <= '0;
    sample_ch.valid    <= 1'b0;
    sample_ch.kind     <= KIND_STEP;
    sample_ch.measured <= '0;
    sample_ch.setpoint <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: moderate gains and limits
    load_settings(GAIN_ONE, GAIN_W'(16), GAIN_W'(512), DW'(2000), DW'(-2000));
    send_item(KIND_STEP, '0, '0);
    send_item(KIND_STEP, DW'(100), DW'(300));
    send_item(KIND_STEP, CTL_BOTTOM, CTL_TOP);
    send_item(KIND_STEP, CTL_TOP, CTL_BOTTOM);
    send_item(KIND_STEP, CTL_TOP, CTL_TOP);
    send_item(KIND_STEP, CTL_BOTTOM, CTL_BOTTOM);
    send_item(KIND_CLEAR, DW'($urandom), DW'($urandom));
    send_item(KIND_STEP, DW'(500), '0);
    send_item(KIND_STEP, '1, DW'(1));
    send_item(KIND_CLEAR, CTL_TOP, CTL_BOTTOM);
    send_item(KIND_CLEAR, CTL_BOTTOM, CTL_TOP);
    send_item(KIND_STEP, DW'(1234), DW'(1200));
    wait_drained();

    // extreme gains, full-range limits
    load_settings(GAIN_BOTTOM, GAIN_TOP, GAIN_BOTTOM, CTL_TOP, CTL_BOTTOM);
    send_item(KIND_STEP, '0, DW'(1));
    send_item(KIND_STEP, CTL_BOTTOM, CTL_TOP);
    send_item(KIND_STEP, CTL_TOP, CTL_BOTTOM);
    send_item(KIND_STEP, '0, '0);
    send_item(KIND_STEP, DW'(-5), DW'(7));
    wait_drained();

    // crossed limits: the low clamp always fires and the result is the lower limit
    load_settings(GAIN_ONE, GAIN_ONE, GAIN_ONE, DW'(-100), DW'(100));
    send_item(KIND_STEP, '0, DW'(50));
    send_item(KIND_STEP, DW'(10), DW'(500));
    send_item(KIND_STEP, DW'(-300), DW'(-1000));
    send_item(KIND_STEP, DW'(20), DW'(20));
    wait_drained();

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int part = 0; part < 2; part++) begin
        a = DW'($urandom);
        b = DW'($urandom);
        roll = $urandom_range(9);
        if (roll < 2) begin
          hi = CTL_TOP;
          lo = CTL_BOTTOM;
        end else if (roll == 2) begin
          hi = (a < b) ? a : b;
          lo = (a < b) ? b : a;
        end else begin
          hi = (a < b) ? b : a;
          lo = (a < b) ? a : b;
        end
        load_settings(pick_gain(), pick_gain(), pick_gain(), hi, lo);
        target = DW'(int'($urandom_range(8000)) - 4000);
        for (int n = 0; n < RANDOM_BEATS; n++) begin
          if ($urandom_range(63) == 0) target = DW'($urandom);
          roll = $urandom_range(99);
          if (roll < 3) begin
            send_item(KIND_CLEAR, DW'($urandom), DW'($urandom));
          end else if (roll < 63) begin
            // loop-like traffic: measurement wandering around the target
            v = int'(target) + int'($urandom_range(1024)) - 512;
            if (v > FIELD_HI) v = FIELD_HI;
            if (v < FIELD_LO) v = FIELD_LO;
            send_item(KIND_STEP, DW'(v), target);
          end else if (roll < 88) begin
            send_item(KIND_STEP, DW'($urandom), DW'($urandom));
          end else begin
            send_item(KIND_STEP, corner_value(), corner_value());
          end
        end
        wait_drained();
      end
    end

    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/pidcl_pkg.sv
hw/rtl/pidcl_in_if.sv
hw/rtl/pidcl_out_if.sv
hw/rtl/pidcl_cfg_regs.sv
hw/rtl/pidcl_step_calc.sv
hw/rtl/pid_with_clamp_antiwindup.sv
bench/pidcl_checker.sv
bench/tb.sv
